// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the key matrix debouncer RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define KMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication
`define KMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kmd_pkg.sv =====
// ---------------------------------------------------------------------------
// kmd_pkg
// Types, constants and register codes of the key matrix debouncer
// ---------------------------------------------------------------------------
package kmd_pkg;

  localparam int unsigned RowCount   = 5;
  localparam int unsigned MatrixW    = 40;
  localparam int unsigned BatteryW   = 10;
  localparam int unsigned StableW    = 8;
  localparam int unsigned IdleW      = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned RowBits    = RowCount * 8;

  localparam logic [MatrixW-1:0] RowMask =
    (RowBits >= MatrixW) ? {MatrixW{1'b1}} :
                           ((MatrixW'(1) << RowBits) - MatrixW'(1));

  localparam logic [StableW-1:0]  StableTicksRst = 8'd5;
  localparam logic [IdleW-1:0]    IdleLimitRst   = 16'd500;
  localparam logic [BatteryW-1:0] BatteryThrRst  = 10'd280;

  localparam logic [CfgIdxW-1:0] CfgStableTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdleLimit   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBatteryThr  = 2'd2;

  typedef enum logic [1:0] {
    OpScan  = 2'd0,
    OpMaint = 2'd1,
    OpWake  = 2'd2
  } op_e;

  typedef struct packed {
    logic [StableW-1:0]  stable_ticks_needed;
    logic [IdleW-1:0]    idle_limit;
    logic [BatteryW-1:0] battery_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [MatrixW-1:0]  matrix_sample;
    logic [BatteryW-1:0] battery_level;
  } item_t;

  typedef struct packed {
    logic               send_valid;
    logic [MatrixW-1:0] key_state;
    logic               sleep_request;
    logic               batt_low;
  } result_t;

endpackage

// ===== rtl/kmd_in_if.sv =====
// ---------------------------------------------------------------------------
// kmd_in_if
// Input channel: operation, raw matrix sample and battery sample
// ---------------------------------------------------------------------------
interface kmd_in_if import kmd_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [MatrixW-1:0]  matrix_sample;
  logic [BatteryW-1:0] battery_level;

  modport source (output valid, output operation, output matrix_sample,
                  output battery_level, input ready);
  modport sink   (input valid, input operation, input matrix_sample,
                  input battery_level, output ready);

endinterface

// ===== rtl/kmd_out_if.sv =====
// ---------------------------------------------------------------------------
// kmd_out_if
// Result channel: send flag, committed key state, sleep and low battery flags
// ---------------------------------------------------------------------------
interface kmd_out_if import kmd_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               send_valid;
  logic [MatrixW-1:0] key_state;
  logic               sleep_request;
  logic               batt_low;

  modport source (output valid, output send_valid, output key_state,
                  output sleep_request, output batt_low, input ready);
  modport sink   (input valid, input send_valid, input key_state,
                  input sleep_request, input batt_low, output ready);

endinterface

// ===== rtl/kmd_in_stage.sv =====
// ---------------------------------------------------------------------------
// kmd_in_stage
// Input register: captures one word per cycle, holds it while stalled
// ---------------------------------------------------------------------------
module kmd_in_stage import kmd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  kmd_in_if.sink  item_i,
  input  logic    advance_i,
  output logic    valid_o,
  output item_t   item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  assign item_i.ready = !valid_q || advance_i;
  assign load         = item_i.valid && item_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (advance_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d                = 1'b1;
      item_d.operation       = item_i.operation;
      item_d.matrix_sample   = item_i.matrix_sample;
      item_d.battery_level   = item_i.battery_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/kmd_engine.sv =====
// ---------------------------------------------------------------------------
// kmd_engine
// Debounce, idle and sleep state with the single-pass update of one word
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kmd_engine import kmd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [MatrixW-1:0] committed_q, committed_d;
  logic [MatrixW-1:0] snap_q, snap_d;
  logic               dbn_q, dbn_d;
  logic [StableW-1:0] cnt_q, cnt_d;
  logic [IdleW-1:0]   idle_q, idle_d;
  logic               asleep_q, asleep_d;

  logic [MatrixW-1:0] sample;
  logic [StableW-1:0] need;
  logic [StableW-1:0] cnt_inc;
  logic [IdleW-1:0]   idle_inc;

  assign sample   = item_i.matrix_sample & RowMask;
  assign need     = (cfg_i.stable_ticks_needed == '0) ? StableW'(1)
                                                       : cfg_i.stable_ticks_needed;
  assign cnt_inc  = cnt_q + StableW'(1);
  assign idle_inc = (idle_q == {IdleW{1'b1}}) ? idle_q : idle_q + IdleW'(1);

  always_comb begin
    committed_d         = committed_q;
    snap_d              = snap_q;
    dbn_d               = dbn_q;
    cnt_d               = cnt_q;
    idle_d              = idle_q;
    asleep_d            = asleep_q;
    res_o.send_valid    = 1'b0;
    res_o.sleep_request = 1'b0;
    res_o.batt_low      = 1'b0;
    unique case (item_i.operation)
      OpScan: begin
        if (!asleep_q) begin
          if (dbn_q) begin
            if (sample == snap_q) begin
              if (cnt_q != {StableW{1'b1}}) begin
                cnt_d = cnt_inc;
                if (cnt_inc == need) begin
                  committed_d      = snap_q;
                  res_o.send_valid = 1'b1;
                end
              end
            end else begin
              dbn_d = 1'b0;
            end
          end else if (sample != committed_q) begin
            snap_d = sample;
            dbn_d  = 1'b1;
            cnt_d  = '0;
          end
          if (sample == '0) begin
            idle_d = idle_inc;
            if (idle_inc > cfg_i.idle_limit) begin
              res_o.sleep_request = 1'b1;
              asleep_d            = 1'b1;
            end
          end else begin
            idle_d = '0;
          end
        end
      end
      OpMaint: begin
        if (!asleep_q) begin
          res_o.send_valid = 1'b1;
          res_o.batt_low   = item_i.battery_level < cfg_i.battery_threshold;
        end
      end
      OpWake: begin
        asleep_d = 1'b0;
        idle_d   = '0;
      end
      default: begin
      end
    endcase
    res_o.key_state = committed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_q <= '0;
      snap_q      <= '0;
      dbn_q       <= 1'b0;
      cnt_q       <= '0;
      idle_q      <= '0;
      asleep_q    <= 1'b0;
    end else if (step_i) begin
      committed_q <= committed_d;
      snap_q      <= snap_d;
      dbn_q       <= dbn_d;
      cnt_q       <= cnt_d;
      idle_q      <= idle_d;
      asleep_q    <= asleep_d;
    end
  end

  `KMD_ASSERT_NXT(a_commit_from_snap,
    step_i && res_o.send_valid && item_i.operation == OpScan,
    committed_q == snap_q, "commit did not take the snapshot")

  `KMD_ASSERT_NXT(a_sleep_sets_asleep, step_i && res_o.sleep_request, asleep_q,
    "sleep request without entering sleep")

  `KMD_ASSERT_IMP(a_asleep_quiet, asleep_q,
    !res_o.send_valid && !res_o.sleep_request && !res_o.batt_low,
    "flag raised while asleep")

endmodule

// ===== rtl/key_matrix_debouncer_core.sv =====
// ---------------------------------------------------------------------------
// key_matrix_debouncer_core
// Path: an accepted word waits in the input register and moves into the result
//   register when it advances, that is when that register is empty or being taken.
// Throughput: one word per cycle unless the result register is stalled, set by the single-pass update.
// Reset: clears all key, debounce, idle and sleep state and both valid flags;
//   configuration returns to 5 stable ticks, idle limit 500, threshold 280.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module key_matrix_debouncer_core import kmd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  kmd_in_if.sink              item_i,
  kmd_out_if.source           result_o
);

  cfg_t    cfg_q, cfg_d;
  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  result_t res;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q, out_res_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStableTicks: cfg_d.stable_ticks_needed = cfg_wdata_i[StableW-1:0];
        CfgIdleLimit:   cfg_d.idle_limit          = cfg_wdata_i[IdleW-1:0];
        CfgBatteryThr:  cfg_d.battery_threshold   = cfg_wdata_i[BatteryW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stable_ticks_needed <= StableTicksRst;
      cfg_q.idle_limit          <= IdleLimitRst;
      cfg_q.battery_threshold   <= BatteryThrRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign advance = s1_valid && (!out_valid_q || result_o.ready);

  kmd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  kmd_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (s1_item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.send_valid    = out_res_q.send_valid;
  assign result_o.key_state     = out_res_q.key_state;
  assign result_o.sleep_request = out_res_q.sleep_request;
  assign result_o.batt_low      = out_res_q.batt_low;

  `KMD_ASSERT_IMP(a_full_stall_blocks_input,
    s1_valid && out_valid_q && !result_o.ready, !item_i.ready,
    "input taken while both stages are stalled")

  `KMD_ASSERT_NXT(a_advance_fills_output, advance, out_valid_q,
    "word left the input register without reaching the result register")

endmodule
